// ----- rtl/cysc_pkg.sv -----
`timescale 1ns / 1ps
package cysc_pkg;

  localparam int IW = 48;
  localparam int UW = 47;
  localparam int LIMB = 32;

  localparam int STRESS_WIDTH_DEF = 48;
  localparam int EXP_TABLE_BITS_DEF = 8;

  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [38:0] ARG_CAP = 39'h40_0000_0000;
  localparam logic [60:0] TERM_CAP = 61'h1000_0000_0000_0000;
  localparam logic [15:0] CAP_RATIO_RESET = 16'h8000;

  typedef enum logic [2:0] {
    REG_SHEAR_A1,
    REG_SHEAR_A2,
    REG_SHEAR_A3,
    REG_SHEAR_A4,
    REG_PEAK,
    REG_CAP_RATIO
  } reg_index_t;

  // integer square root, used at elaboration only
  function automatic longint unsigned isqrt64(input longint unsigned val);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bt;
    v = val;
    res = 0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-(j+1)) in q2.30
  function automatic logic [31:0] exp_root(input int j);
    longint unsigned r;
    r = isqrt64(64'd1 << 61);
    for (int k = 0; k < j; k++) begin
      r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

// ----- rtl/cap_yield_surface_check_core.sv -----
`timescale 1ns / 1ps
// channel   | handshake                   | payload
// ----------+-----------------------------+--------------------------------------------
// command   | start, busy (always low)    | first_invariant, back_stress, cap_position,
//           |                             | root_j2
// result    | done (one-cycle strobe)     | yield_flag
// config    | cfg_valid, cfg_ready (high) | cfg_index, cfg_data
//
// one request per cycle; done is registered from the valid bit of the last pipeline stage
// the pipeline depth is set by the exp mantissa chain (one table root per stage) and the
// three-stage limb multipliers of the cap test
// rst is synchronous: clears the stage valid bits, done and the configuration registers
// the result side has no backpressure, so the pipeline never stalls
module cap_yield_surface_check_core #(
  parameter int STRESS_WIDTH   = cysc_pkg::STRESS_WIDTH_DEF,
  parameter int EXP_TABLE_BITS = cysc_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [STRESS_WIDTH-1:0] first_invariant,
  input  logic [STRESS_WIDTH-1:0] back_stress,
  input  logic [STRESS_WIDTH-1:0] cap_position,
  input  logic [STRESS_WIDTH-2:0] root_j2,
  output logic                    done,
  output logic                    yield_flag,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [cysc_pkg::IW-1:0] cfg_data
);
  import cysc_pkg::*;

  localparam int EB = EXP_TABLE_BITS;
  // peak and root_j2 keep this many low bits
  localparam int PB = (STRESS_WIDTH - 1 < UW) ? STRESS_WIDTH - 1 : UW;
  localparam logic [UW-1:0] PMASK = UW'((64'd1 << PB) - 64'd1);
  localparam logic [31:0] RMASK = 32'((64'd1 << (32 - EB)) - 64'd1);
  localparam longint S_MAX = (longint'(1) <<< (IW - 1)) - 1;
  localparam longint S_MIN = -(longint'(1) <<< (IW - 1));

  // stage map
  localparam int ST_M = 13 + EB;     // final mantissa
  localparam int NST = ST_M + 13;    // last pipeline stage

  typedef struct packed {
    logic signed [47:0] i1;
    logic signed [47:0] zeta;
    logic signed [47:0] capx;
    logic [46:0]        sj;
    logic signed [48:0] ieff;
    logic signed [48:0] diff;
    logic [48:0]        ieff_mag;
    logic               ieff_neg;
    logic [47:0]        diff_mag;
    logic               diff_neg;
    logic [38:0]        arg_mag;
    logic               arg_neg;
    logic               arg_hi;
    logic               arg_lo;
    logic signed [61:0] lin;
    logic signed [48:0] q;
    logic signed [49:0] kappa;
    logic [48:0]        d;
    logic [48:0]        u;
    logic [49:0]        v;
    logic               below;
    logic               incap;
    logic               beyond;
    logic signed [9:0]  n;
    logic [31:0]        f;
    logic [31:0]        rl;
    logic [31:0]        m;
    logic [63:0]        mprod;
    logic [60:0]        termmag;
    logic signed [61:0] term;
    logic signed [63:0] ff;
    logic [62:0]        ffmag;
    logic               shear;
    logic [98:0]        cval;
    logic [191:0]       lhs;
  } pipe_t;

  function automatic logic signed [IW-1:0] clamp_s(input logic signed [STRESS_WIDTH-1:0] s);
    if (s > S_MAX) begin
      return IW'(S_MAX);
    end else if (s < S_MIN) begin
      return IW'(S_MIN);
    end else begin
      return IW'(s);
    end
  endfunction

  // configuration registers
  logic [47:0] reg_a1;
  logic [47:0] reg_a2;
  logic [47:0] reg_a3;
  logic [47:0] reg_a4;
  logic [46:0] reg_peak;
  logic [15:0] reg_cr;

  // registered config; user keeps it stable while requests are in flight, unenforced
  logic signed [47:0] a1_c;
  logic [47:0]        a2_mag;
  logic               a2_neg;
  logic [47:0]        a3_mag;
  logic               a3_neg;
  logic               a3_zero;
  logic [47:0]        a4_mag;
  logic               a4_neg;
  logic [46:0]        peak_c;
  logic [15:0]        cr_c;

  logic signed [47:0] a3_s;
  logic signed [47:0] a2_s;
  logic signed [47:0] a4_s;

  pipe_t pipe [1:NST];
  logic  vld  [1:NST];

  // multiplier results
  logic [63:0]  m0_p;
  logic [96:0]  m1_p;
  logic [71:0]  m2_p;
  logic [79:0]  m3_p;
  logic [96:0]  m4_p;
  logic [95:0]  m5_p;
  logic [98:0]  m6_p;
  logic [191:0] m7_p;
  logic [125:0] m8_p;
  logic [224:0] m9_p;

  logic [63:0] chain_prod [EB];

  // stage logic
  logic signed [48:0] s2_ieff;
  logic signed [48:0] s2_diff;
  logic [72:0]        s7_argw;
  logic [38:0]        s7_arg_mag;
  logic [64:0]        s7_linw;
  logic [60:0]        s7_lin_mag;
  logic signed [61:0] s7_lin;
  logic [48:0]        s7_qmag;
  logic signed [48:0] s7_q;
  logic signed [51:0] s9_k;
  logic signed [51:0] s9_c;
  logic signed [51:0] s9_e;
  logic [39:0]        s11_ym;
  logic [63:0]        s12_rprod;
  logic signed [9:0]  sx_amt;
  logic [142:0]       sx_wide;
  logic [60:0]        sx_tmag;
  logic               fin_res;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a1 <= '0;
      reg_a2 <= '0;
      reg_a3 <= '0;
      reg_a4 <= '0;
      reg_peak <= '0;
      reg_cr <= CAP_RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHEAR_A1: reg_a1 <= cfg_data;
        REG_SHEAR_A2: reg_a2 <= cfg_data;
        REG_SHEAR_A3: reg_a3 <= cfg_data;
        REG_SHEAR_A4: reg_a4 <= cfg_data;
        REG_PEAK: reg_peak <= cfg_data[46:0];
        REG_CAP_RATIO: reg_cr <= cfg_data[15:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign a3_s = clamp_s($signed(STRESS_WIDTH'(reg_a3)));
  assign a2_s = $signed(reg_a2);
  assign a4_s = $signed(reg_a4);

  always_ff @(posedge clk) begin
    a1_c <= clamp_s($signed(STRESS_WIDTH'(reg_a1)));
    a2_mag <= a2_s[47] ? $unsigned(-a2_s) : $unsigned(a2_s);
    a2_neg <= a2_s[47];
    a3_mag <= a3_s[47] ? $unsigned(-a3_s) : $unsigned(a3_s);
    a3_neg <= a3_s[47];
    a3_zero <= (a3_s == '0);
    a4_mag <= a4_s[47] ? $unsigned(-a4_s) : $unsigned(a4_s);
    a4_neg <= a4_s[47];
    peak_c <= reg_peak & PMASK;
    cr_c <= reg_cr;
  end

  // limb multipliers, each registered at its partial products, its rows and its output
  cysc_mul #(.AW(48), .BW(16)) u_m0 (
    .clk(clk), .a(pipe[3].diff_mag), .b(cr_c), .p(m0_p));
  cysc_mul #(.AW(49), .BW(48)) u_m1 (
    .clk(clk), .a(pipe[3].ieff_mag), .b(a2_mag), .p(m1_p));
  cysc_mul #(.AW(49), .BW(48)) u_m4 (
    .clk(clk), .a(pipe[3].ieff_mag), .b(a4_mag), .p(m4_p));
  cysc_mul #(.AW(39), .BW(33)) u_m2 (
    .clk(clk), .a(pipe[7].arg_mag), .b(LOG2E_Q32), .p(m2_p));
  cysc_mul #(.AW(47), .BW(49)) u_m5 (
    .clk(clk), .a(pipe[9].sj), .b(pipe[9].d), .p(m5_p));
  cysc_mul #(.AW(49), .BW(50)) u_m6 (
    .clk(clk), .a(pipe[9].u), .b(pipe[9].v), .p(m6_p));
  cysc_mul #(.AW(96), .BW(96)) u_m7 (
    .clk(clk), .a(m5_p), .b(m5_p), .p(m7_p));
  cysc_mul #(.AW(48), .BW(32)) u_m3 (
    .clk(clk), .a(a3_mag), .b(pipe[ST_M].m), .p(m3_p));
  cysc_mul #(.AW(63), .BW(63)) u_m8 (
    .clk(clk), .a(pipe[ST_M+7].ffmag), .b(pipe[ST_M+7].ffmag), .p(m8_p));
  cysc_mul #(.AW(126), .BW(99)) u_m9 (
    .clk(clk), .a(m8_p), .b(pipe[ST_M+10].cval), .p(m9_p));

  // exp mantissa chain: one table root per stage
  genvar gj;
  generate
    for (gj = 0; gj < EB; gj++) begin : g_root
      localparam logic [31:0] ROOT = exp_root(gj);
      assign chain_prod[gj] = 64'(pipe[11+gj].m) * 64'(ROOT);
    end
  endgenerate

  always_comb begin
    s2_ieff = 49'(pipe[1].i1) - 49'(pipe[1].zeta);
    s2_diff = $signed({2'b00, peak_c}) - 49'(pipe[1].capx);

    // exponent argument, saturated to +-64
    s7_argw = 73'(m1_p >> 24);
    s7_arg_mag = (s7_argw > 73'(ARG_CAP)) ? ARG_CAP : s7_argw[38:0];

    // linear term
    s7_linw = 65'(m4_p >> 32);
    s7_lin_mag = (s7_linw > 65'(TERM_CAP)) ? TERM_CAP : s7_linw[60:0];
    s7_lin = (pipe[6].ieff_neg ^ a4_neg) ? -$signed({1'b0, s7_lin_mag})
                                         : $signed({1'b0, s7_lin_mag});

    // cr * (peak - x), floored
    s7_qmag = {1'b0, m0_p[63:16]} + 49'(|m0_p[15:0]);
    s7_q = pipe[6].diff_neg ? $signed(~s7_qmag + 49'd1) : $signed({1'b0, m0_p[63:16]});

    s9_k = 52'(pipe[8].kappa);
    s9_c = 52'(pipe[8].capx);
    s9_e = 52'(pipe[8].ieff);

    s11_ym = m2_p[71:32];

    s12_rprod = 64'(pipe[11].f & RMASK) * 64'(LN2_Q32);

    // scale by 2^n: window holds the product shifted up by 63
    sx_amt = 10'sd93 - pipe[ST_M+3].n;
    sx_wide = {m3_p, 63'b0} >> 8'(sx_amt);
    if (|sx_wide[142:61]) begin
      sx_tmag = TERM_CAP;
    end else if (sx_wide[60:0] > TERM_CAP) begin
      sx_tmag = TERM_CAP;
    end else begin
      sx_tmag = sx_wide[60:0];
    end

    if (pipe[NST].below) begin
      fin_res = 1'b1;
    end else if (pipe[NST].incap) begin
      fin_res = {33'b0, pipe[NST].lhs} > m9_p;
    end else if (pipe[NST].beyond) begin
      fin_res = 1'b1;
    end else begin
      fin_res = pipe[NST].shear;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    for (int k = 2; k <= NST; k++) begin
      pipe[k] <= pipe[k-1];
    end

    pipe[1].i1 <= clamp_s($signed(first_invariant));
    pipe[1].zeta <= clamp_s($signed(back_stress));
    pipe[1].capx <= clamp_s($signed(cap_position));
    pipe[1].sj <= UW'(root_j2) & PMASK;

    pipe[2].ieff <= s2_ieff;
    pipe[2].diff <= s2_diff;

    pipe[3].ieff_neg <= pipe[2].ieff[48];
    pipe[3].ieff_mag <= pipe[2].ieff[48] ? $unsigned(-pipe[2].ieff) : $unsigned(pipe[2].ieff);
    pipe[3].diff_neg <= pipe[2].diff[48];
    pipe[3].diff_mag <= pipe[2].diff[48] ? 48'($unsigned(-pipe[2].diff))
                                         : 48'($unsigned(pipe[2].diff));

    pipe[7].arg_mag <= s7_arg_mag;
    pipe[7].arg_neg <= pipe[6].ieff_neg ^ a2_neg;
    pipe[7].arg_hi <= (s7_arg_mag == ARG_CAP) && !(pipe[6].ieff_neg ^ a2_neg);
    pipe[7].arg_lo <= (s7_arg_mag == ARG_CAP) && (pipe[6].ieff_neg ^ a2_neg);
    pipe[7].lin <= s7_lin;
    pipe[7].q <= s7_q;

    pipe[8].kappa <= $signed({3'b000, peak_c}) - 50'(pipe[7].q);

    // cap region geometry
    pipe[9].d <= 49'(s9_k - s9_c);
    pipe[9].u <= 49'(s9_e - s9_c);
    pipe[9].v <= 50'((s9_k - s9_c) + (s9_k - s9_e));
    pipe[9].below <= s9_e < s9_c;
    pipe[9].incap <= (s9_c < s9_e) && (s9_e < s9_k);
    pipe[9].beyond <= s9_e > $signed({5'b00000, pipe[8].sj[0] & 1'b0, peak_c[46:0]} >>> 0);

    // split y into integer and fraction, floor semantics
    if (pipe[10].arg_neg) begin
      pipe[11].n <= -(10'(s11_ym[39:32]) + 10'(s11_ym[31:0] != 32'd0));
      pipe[11].f <= -s11_ym[31:0];
    end else begin
      pipe[11].n <= 10'(s11_ym[39:32]);
      pipe[11].f <= s11_ym[31:0];
    end
    pipe[11].m <= 32'h4000_0000;

    pipe[12].rl <= s12_rprod[63:32];

    pipe[13].cval <= m6_p;
    pipe[16].lhs <= m7_p;

    for (int j = 0; j < EB; j++) begin
      pipe[12+j].m <= pipe[11+j].f[31-j] ? chain_prod[j][61:30] : pipe[11+j].m;
    end

    pipe[12+EB].mprod <= 64'(pipe[11+EB].m) * 64'(pipe[11+EB].rl);
    pipe[ST_M].m <= pipe[ST_M-1].m + pipe[ST_M-1].mprod[63:32];

    pipe[ST_M+4].termmag <= sx_tmag;

    if (pipe[ST_M+4].arg_lo) begin
      pipe[ST_M+5].term <= '0;
    end else if (pipe[ST_M+4].arg_hi) begin
      if (a3_zero) begin
        pipe[ST_M+5].term <= '0;
      end else if (a3_neg) begin
        pipe[ST_M+5].term <= -$signed({1'b0, TERM_CAP});
      end else begin
        pipe[ST_M+5].term <= $signed({1'b0, TERM_CAP});
      end
    end else begin
      pipe[ST_M+5].term <= a3_neg ? -$signed({1'b0, pipe[ST_M+4].termmag})
                                  : $signed({1'b0, pipe[ST_M+4].termmag});
    end

    // shear limit
    pipe[ST_M+6].ff <= 64'(a1_c) - 64'(pipe[ST_M+5].term) - 64'(pipe[ST_M+5].lin);

    pipe[ST_M+7].ffmag <= pipe[ST_M+6].ff[63] ? 63'($unsigned(-pipe[ST_M+6].ff))
                                              : 63'($unsigned(pipe[ST_M+6].ff));
    pipe[ST_M+7].shear <= $signed({17'b0, pipe[ST_M+6].sj}) > pipe[ST_M+6].ff;
  end

  // valid bits and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NST; k++) begin
        vld[k] <= 1'b0;
      end
      done <= 1'b0;
    end else begin
      vld[1] <= start && !busy;
      for (int k = 2; k <= NST; k++) begin
        vld[k] <= vld[k-1];
      end
      done <= vld[NST];
    end
  end

  always_ff @(posedge clk) begin
    yield_flag <= fin_res;
  end

endmodule

// ----- rtl/cysc_mul.sv -----
`timescale 1ns / 1ps
module cysc_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic               clk,
  input  logic [AW-1:0]      a,
  input  logic [BW-1:0]      b,
  output logic [AW+BW-1:0]   p
);
  import cysc_pkg::*;

  localparam int NA = (AW + LIMB - 1) / LIMB;
  localparam int NB = (BW + LIMB - 1) / LIMB;
  localparam int AEW = NA * LIMB;
  localparam int BEW = NB * LIMB;
  localparam int PW = AEW + BEW;

  logic [AEW-1:0]    a_ext;
  logic [BEW-1:0]    b_ext;
  logic [2*LIMB-1:0] pp [NA][NB];
  logic [PW-1:0]     row_sum [NA];
  logic [PW-1:0]     row [NA];
  logic [PW-1:0]     total;

  assign a_ext = AEW'(a);
  assign b_ext = BEW'(b);

  // limb partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= a_ext[i*LIMB +: LIMB] * b_ext[j*LIMB +: LIMB];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_sum[i] = row_sum[i] + (PW'(pp[i][j]) << (j * LIMB));
      end
    end
  end

  always_ff @(posedge clk) begin
    row <= row_sum;
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < NA; i++) begin
      total = total + (row[i] << (i * LIMB));
    end
  end

  always_ff @(posedge clk) begin
    p <= total[AW+BW-1:0];
  end

endmodule

// ----- tb/cap_yield_surface_check_core_test.sv -----
`timescale 1ns / 1ps
module cap_yield_surface_check_core_test;
  import cysc_pkg::*;

  // upper bound on the request-to-result latency at the default table size
  localparam int PIPE_LATENCY = 35;
  localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
  localparam int STALL_LIMIT  = 4000;

  // register codes past the end of the register file, written to check they are dropped
  localparam logic [2:0] REG_BEYOND_LIST = 3'd6;
  localparam logic [2:0] REG_TOP_CODE    = 3'd7;

  // fixed-point constants of the exp unit
  localparam longint unsigned LOG2E_SCALED = 64'd6196328019;
  localparam longint unsigned LN2_SCALED   = 64'd2977044472;
  localparam logic [255:0]    EXP_ARG_SAT  = 256'd1 << 38;
  localparam logic [255:0]    SHEAR_SAT    = 256'd1 << 60;
  localparam logic [255:0]    LOG_ARG_SAT  = (256'd1 << 62) - 1;
  localparam int              ROOT_STAGES  = 8;

  localparam logic [47:0] MAX_S48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN_S48 = 48'h8000_0000_0000;
  localparam logic [46:0] MAX_U47 = 47'h7FFF_FFFF_FFFF;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [47:0] first_invariant = '0;
  logic [47:0] back_stress = '0;
  logic [47:0] cap_position = '0;
  logic [46:0] root_j2 = '0;
  logic        done;
  logic        yield_flag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  cap_yield_surface_check_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_invariant(first_invariant), .back_stress(back_stress),
    .cap_position(cap_position), .root_j2(root_j2),
    .done(done), .yield_flag(yield_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the register file, masked to register widths
  logic [47:0] shadow_reg [6];

  // yield flags still owed by the pipeline, oldest first
  logic yield_expect [$];

  int  mismatches = 0;
  int  points_sent = 0;
  int  flags_checked = 0;
  int  yielded_seen = 0;
  int  reg_writes = 0;
  int  stall_cycles = 0;
  bit  idling_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem = val;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // |a*b| >> sh, saturated, with the sign of the product
  function automatic longint scaled_product(input longint a, input longint b, input int sh,
                                            input logic [255:0] sat);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [255:0] p;
    longint       r;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ({192'd0, ma} * {192'd0, mb}) >> sh;
    if (p > sat) p = sat;
    r = longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // a3 * 2^(arg*log2e), arg in q.32, result in stress units
  function automatic longint shear_exp_term(input longint a3, input longint arg);
    longint          y;
    longint          n;
    longint unsigned frac;
    longint unsigned mant;
    longint unsigned root;
    longint unsigned rlow;
    logic [63:0]     ma3;
    logic [255:0]    p;
    int              sh;
    longint          r;
    if (arg >= longint'(EXP_ARG_SAT[63:0]))
      return (a3 > 0) ? longint'(SHEAR_SAT[63:0]) :
             (a3 < 0) ? -longint'(SHEAR_SAT[63:0]) : 0;
    if (arg <= -longint'(EXP_ARG_SAT[63:0])) return 0;
    y = scaled_product(arg, longint'(LOG2E_SCALED), 32, LOG_ARG_SAT);
    n = y >>> 32;
    frac = y & 64'hFFFF_FFFF;
    mant = 64'd1 << 30;
    root = int_sqrt(64'd1 << 61);
    for (int j = 0; j < ROOT_STAGES; j++) begin
      if (frac[31-j]) mant = (mant * root) >> 30;
      root = int_sqrt(root << 30);
    end
    rlow = ((frac & ((64'd1 << (32 - ROOT_STAGES)) - 1)) * LN2_SCALED) >> 32;
    mant = mant + ((mant * rlow) >> 32);
    ma3 = (a3 < 0) ? -a3 : a3;
    p = {192'd0, ma3} * {192'd0, mant};
    sh = 30 - int'(n);
    if (sh >= 0) p = p >> sh;
    else p = p << (-sh);
    if (p > SHEAR_SAT) p = SHEAR_SAT;
    r = longint'(p[63:0]);
    return (a3 < 0) ? -r : r;
  endfunction

  function automatic logic predict_yield(input logic [47:0] fi, input logic [47:0] bs,
                                         input logic [47:0] cp, input logic [46:0] rj);
    longint       a1, a2, a3, a4, peak, i1, zeta, capx, sj, ieff, diff, q, kappa, ff, d;
    logic [79:0]  pm;
    logic [63:0]  mdiff;
    logic [63:0]  mff;
    logic [255:0] lhs;
    logic [255:0] rhs;
    a1 = $signed(shadow_reg[REG_SHEAR_A1]);
    a2 = $signed(shadow_reg[REG_SHEAR_A2]);
    a3 = $signed(shadow_reg[REG_SHEAR_A3]);
    a4 = $signed(shadow_reg[REG_SHEAR_A4]);
    peak = longint'({17'd0, shadow_reg[REG_PEAK][46:0]});
    i1 = $signed(fi);
    zeta = $signed(bs);
    capx = $signed(cp);
    sj = longint'({17'd0, rj});
    ieff = i1 - zeta;
    diff = peak - capx;
    mdiff = (diff < 0) ? -diff : diff;
    pm = {64'd0, shadow_reg[REG_CAP_RATIO][15:0]} * {16'd0, mdiff};
    // floor toward minus infinity on the branch offset
    if (diff >= 0) q = longint'(pm >> 16);
    else q = -longint'((pm >> 16) + ((pm[15:0] != 0) ? 1 : 0));
    kappa = peak - q;
    ff = a1 - shear_exp_term(a3, scaled_product(a2, ieff, 24, EXP_ARG_SAT))
            - scaled_product(a4, ieff, 32, SHEAR_SAT);
    if (ieff < capx) return 1'b1;
    if (capx < ieff && ieff < kappa) begin
      // elliptical cap, cross-multiplied
      d = kappa - capx;
      mff = (ff < 0) ? -ff : ff;
      lhs = {192'd0, 64'(sj)} * {192'd0, 64'(sj)} * {192'd0, 64'(d)} * {192'd0, 64'(d)};
      rhs = {192'd0, mff} * {192'd0, mff} * {192'd0, 64'(ieff - capx)}
            * {192'd0, 64'(d + (kappa - ieff))};
      return lhs > rhs;
    end
    if (ieff <= peak) return sj > ff;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // request and register drivers
  // ---------------------------------------------------------------------------

  task automatic send_point(input logic [47:0] fi, input logic [47:0] bs,
                            input logic [47:0] cp, input logic [46:0] rj);
    start <= 1'b1;
    first_invariant <= fi;
    back_stress <= bs;
    cap_position <= cp;
    root_j2 <= rj;
    @(posedge clk);
    while (busy) @(posedge clk);
    yield_expect.push_back(predict_yield(fi, bs, cp, rj));
    points_sent++;
    // random sender gaps; start stays high across back-to-back requests
    if (idling_on && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // hold off until the pipeline has delivered every owed flag
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (yield_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_SHEAR_A1, REG_SHEAR_A2, REG_SHEAR_A3, REG_SHEAR_A4: begin
        shadow_reg[idx] = val;
      end
      REG_PEAK: begin
        shadow_reg[idx] = {1'b0, val[46:0]};
      end
      REG_CAP_RATIO: begin
        shadow_reg[idx] = {32'd0, val[15:0]};
      end
      default: begin
        // codes past the register file are dropped
      end
    endcase
    // cfg_valid is low again before the next write
    @(posedge clk);
  endtask

  task automatic load_shear(input logic [47:0] a1, input logic [47:0] a2,
                            input logic [47:0] a3, input logic [47:0] a4,
                            input logic [47:0] peak, input logic [47:0] cr);
    drain_pipeline();
    write_register(REG_SHEAR_A1, a1);
    write_register(REG_SHEAR_A2, a2);
    write_register(REG_SHEAR_A3, a3);
    write_register(REG_SHEAR_A4, a4);
    write_register(REG_PEAK, peak);
    write_register(REG_CAP_RATIO, cr);
  endtask

  function automatic logic [47:0] rand_bits48();
    return 48'({$urandom, $urandom});
  endfunction

  // random value in [0, 2^w)
  function automatic longint rand_below(input int w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    return longint'(r & ((64'd1 << w) - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: one flag per strobe, compared with the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && done) begin
      if (yield_expect.size() == 0) begin
        $display("%0t: unexpected result strobe, expected none, actual yield_flag=%0b",
                 $time, yield_flag);
        mismatches++;
      end else begin
        logic want;
        want = yield_expect.pop_front();
        flags_checked++;
        if (yield_flag) yielded_seen++;
        if (yield_flag !== want) begin
          $display("%0t: yield_flag mismatch, expected %0b, actual %0b",
                   $time, want, yield_flag);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles where no request, no result and no register write moves
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("cap_yield_surface_check_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values: zero shear limit, half cap ratio, zero peak
  task automatic test_reset_defaults();
    send_point(48'd0, 48'd0, 48'd0, 47'd0);
    send_point(-48'sd100, 48'd0, 48'd0, 47'd5);
    send_point(48'd100, 48'd0, 48'd0, 47'd0);
    send_point(MAX_S48, MIN_S48, MIN_S48, MAX_U47);
  endtask

  // one point per branch plus field extremes on a plain surface
  task automatic test_branches();
    // a1 = 100.0, gentle exp and linear terms, peak 50.0, cap at -200.0
    load_shear(48'd100 << 16, 48'd1 << 20, 48'd10 << 16, 48'd1 << 28,
               48'd50 << 16, 48'd32768);
    send_point(-(48'sd300 << 16), 48'd0, -(48'sd200 << 16), 47'd0);    // below the cap
    send_point(-(48'sd200 << 16), 48'd0, -(48'sd200 << 16), 47'd1);    // on the cap
    send_point(-(48'sd190 << 16), 48'd0, -(48'sd200 << 16), 47'd1 << 16);
    send_point(-(48'sd120 << 16), 48'd0, -(48'sd200 << 16), 47'd90 << 16);
    send_point(48'd10 << 16, 48'd0, -(48'sd200 << 16), 47'd20 << 16); // shear region
    send_point(48'd10 << 16, 48'd0, -(48'sd200 << 16), 47'd200 << 16);
    send_point(48'd60 << 16, 48'd0, -(48'sd200 << 16), 47'd0);         // beyond the peak
    send_point(48'd60 << 16, 48'd20 << 16, -(48'sd200 << 16), 47'd0);  // back stress shift
    send_point(MIN_S48, MAX_S48, MAX_S48, MAX_U47);
    send_point(MAX_S48, 48'd0, MIN_S48, 47'd0);
    send_point(48'd0, 48'd0, MAX_S48, 47'd0);                          // empty cap region
  endtask

  // exponent saturating high and low, cap ratio at its ends, dropped codes
  task automatic test_exp_and_ratio_ends();
    load_shear(MAX_S48, MAX_S48, 48'd1 << 30, MIN_S48, MAX_U47, 48'd0);
    write_register(REG_BEYOND_LIST, 48'hABCD);
    write_register(REG_TOP_CODE, MAX_S48);
    send_point(48'd1 << 40, 48'd0, MIN_S48, 47'd1 << 20);
    send_point(-(48'sd1 << 40), 48'd0, MIN_S48, 47'd1 << 20);
    send_point(48'd0, 48'd0, MIN_S48, 47'd0);
    load_shear(MIN_S48, MIN_S48, MIN_S48, MAX_S48, 48'd0, 48'd65535);
    send_point(48'd1 << 40, 48'd0, MIN_S48, 47'd0);
    send_point(-(48'sd1 << 40), 48'd0, MIN_S48, MAX_U47);
    send_point(-(48'sd5 << 16), 48'd0, -(48'sd9 << 16), 47'd3);
    load_shear(48'd1 << 36, MIN_S48, MIN_S48, 48'd0, 48'd1 << 30, 48'd1);
    send_point(48'd1 << 40, 48'd0, -(48'sd1 << 30), 47'd1);
    send_point(48'd1, 48'd0, -(48'sd1 << 30), 47'd1 << 17);
  endtask

  // one random surface and a burst of points scaled to it
  task automatic test_random_phase(input int count);
    longint a1, a3, peak, capx, ieff, zeta, margin, span, off, rj;
    int     s;
    s = $urandom_range(18, 40);
    a1 = rand_below(s + 1) + 1;
    a3 = rand_below(s - 2) - rand_below(s - 3);
    peak = rand_below(s);
    load_shear(48'(a1), 48'(rand_below(56 - s) - rand_below(56 - s)), 48'(a3),
               48'(rand_below(29) - rand_below(29)), 48'(peak),
               48'($urandom_range(0, 65535)));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        // well-formed point around the cap and shear regions
        capx = -rand_below(s + 1);
        margin = longint'(64'd1 << (s - 4));
        span = peak - capx + 2 * margin;
        off = longint'(64'(rand_below(62)) % 64'(span)) - margin;
        ieff = capx + off;
        zeta = rand_below(s - 2) - rand_below(s - 2);
        rj = rand_below(s + 2);
        send_point(48'(ieff + zeta), 48'(zeta), 48'(capx), 47'(rj));
      end else begin
        send_point(rand_bits48(), rand_bits48(), rand_bits48(), 47'(rand_bits48()));
      end
    end
  endtask

  initial begin
    shadow_reg[REG_SHEAR_A1] = '0;
    shadow_reg[REG_SHEAR_A2] = '0;
    shadow_reg[REG_SHEAR_A3] = '0;
    shadow_reg[REG_SHEAR_A4] = '0;
    shadow_reg[REG_PEAK] = '0;
    shadow_reg[REG_CAP_RATIO] = 48'(CAP_RATIO_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_branches();
    test_exp_and_ratio_ends();
    for (int ph = 0; ph < 5; ph++) test_random_phase(200);
    // last stretch runs back to back with no sender gaps
    idling_on = 1'b0;
    test_random_phase(200);

    drain_pipeline();
    $display("covered %0d points over %0d register writes, %0d flags checked (%0d yielded)",
             points_sent, reg_writes, flags_checked, yielded_seen);
    $display("branches: below cap, cap ellipse, shear, beyond peak, exp saturation, ratio ends");
    if (mismatches == 0 && yield_expect.size() == 0) begin
      $display("cap_yield_surface_check_core regression: pass");
    end else begin
      $display("cap_yield_surface_check_core regression: fail");
    end
    $finish;
  end

endmodule
